>>> rtl/core/image_box_downscale_2x2_top_macros.svh
// Assertion macros shared by the checker of the 2x2 box downscaler.
// Depends on nothing; the including scope must provide clk_i and rst_ni.
`ifndef IMAGE_BOX_DOWNSCALE_2X2_TOP_MACROS_SVH
`define IMAGE_BOX_DOWNSCALE_2X2_TOP_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define IBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication whose consequent must hold in the cycle after its trigger.
`define IBD_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ibd_pkg.sv
// Types and constants of the 2x2 box downscaler.
// Used by every module under rtl/core; depends on nothing.
package ibd_pkg;

  localparam int CHAN_W     = 8;
  localparam int PAIR_W     = CHAN_W + 1;
  localparam int SUM_W      = PAIR_W + 1;
  localparam int NUM_CHAN   = 3;
  localparam int LINE_W     = NUM_CHAN * PAIR_W;
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 12;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(480);

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              frame_last;
  } pix_out_t;

  typedef struct packed {
    logic               wr_en;
    logic               rd_en;
    logic [LINE_AW-1:0] addr;
    logic [LINE_W-1:0]  wdata;
  } line_req_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/image_box_downscale_2x2_top.sv
// Top level of the 2x2 box downscaler: counters, config registers, lanes.
// Depends on ibd_pkg, ibd_lane, ibd_line_mem and ibd_out_buf.
//
//   channel | signals                                | width
//   in      | in_valid_i, in_stall_o, in_pix_i       | 24
//   out     | out_valid_o, out_stall_i, out_pix_o    | 25
//   config  | psel, penable, pwrite, paddr, pwdata   | 32
//
// One pixel per cycle unless in_stall_o; results are registered in u_out.
// The line store is read at the even column so its registered data is ready
// for the odd column. Reset gives a 640x480 frame and no clearing pass.
// in_stall_o rises only after a result meets a held, stalled result.
module image_box_downscale_2x2_top
  import ibd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pix_in_t           in_pix_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pix_out_t          out_pix_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [SIZE_W-1:0] width_q, width_d;
  logic [SIZE_W-1:0] height_q, height_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  pix_in_t           pend_q;
  logic [SIZE_W-1:0] w_eff, h_eff;
  logic              cfg_wr, accept, odd_col, odd_row, row_end, frame_end, push;
  line_req_t         line_req;
  logic [LINE_W-1:0] above;
  logic [CHAN_W-1:0] left_ch  [NUM_CHAN];
  logic [CHAN_W-1:0] right_ch [NUM_CHAN];
  logic [PAIR_W-1:0] pair_ch  [NUM_CHAN];
  logic [CHAN_W-1:0] avg_ch   [NUM_CHAN];
  pix_out_t          result;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_WIDTH:  width_d  = pwdata[SIZE_W-1:0];
        REG_HEIGHT: height_d = pwdata[SIZE_W-1:0];
        default:    width_d  = width_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = APB_DW'(width_q);
      REG_HEIGHT: prdata = APB_DW'(height_q);
      default:    prdata = '0;
    endcase
  end

  assign w_eff = clamp_size(width_q, SIZE_W'(MAX_WIDTH));
  assign h_eff = clamp_size(height_q, SIZE_W'(MAX_HEIGHT));

  assign accept    = in_valid_i & ~in_stall_o;
  assign odd_col   = col_q[0];
  assign odd_row   = row_q[0];
  assign row_end   = (SIZE_W'(col_q) + SIZE_W'(1)) >= w_eff;
  assign frame_end = (SIZE_W'(row_q) + SIZE_W'(1)) >= h_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_wr) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !odd_col) begin
      pend_q <= in_pix_i;
    end
  end

  assign left_ch[0]  = pend_q.red_in;
  assign left_ch[1]  = pend_q.green_in;
  assign left_ch[2]  = pend_q.blue_in;
  assign right_ch[0] = in_pix_i.red_in;
  assign right_ch[1] = in_pix_i.green_in;
  assign right_ch[2] = in_pix_i.blue_in;

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
    ibd_lane u_lane (
      .left_i  (left_ch[c]),
      .right_i (right_ch[c]),
      .above_i (above[(NUM_CHAN-1-c)*PAIR_W +: PAIR_W]),
      .pair_o  (pair_ch[c]),
      .avg_o   (avg_ch[c])
    );
  end

  assign line_req.wr_en = accept & odd_col & ~odd_row;
  assign line_req.rd_en = accept & ~odd_col;
  assign line_req.addr  = col_q[COL_W-1:1];
  assign line_req.wdata = {pair_ch[0], pair_ch[1], pair_ch[2]};

  ibd_line_mem u_line (
    .clk_i   (clk_i),
    .req_i   (line_req),
    .rdata_o (above)
  );

  assign push = accept & odd_col & odd_row;

  assign result.red_out    = avg_ch[0];
  assign result.green_out  = avg_ch[1];
  assign result.blue_out   = avg_ch[2];
  assign result.frame_last = ((SIZE_W'(col_q) + SIZE_W'(2)) >= w_eff) &&
                             ((SIZE_W'(row_q) + SIZE_W'(2)) >= h_eff);

  ibd_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (result),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_pix_o   (out_pix_o)
  );

endmodule

>>> rtl/core/ibd_lane.sv
// One channel lane: horizontal pair sum and rounded 2x2 average.
// Depends on ibd_pkg.
module ibd_lane
  import ibd_pkg::*;
(
  input  logic [CHAN_W-1:0] left_i,
  input  logic [CHAN_W-1:0] right_i,
  input  logic [PAIR_W-1:0] above_i,
  output logic [PAIR_W-1:0] pair_o,
  output logic [CHAN_W-1:0] avg_o
);

  logic [SUM_W-1:0] sum;

  assign pair_o = PAIR_W'(left_i) + PAIR_W'(right_i);
  assign sum    = SUM_W'(above_i) + SUM_W'(pair_o) + SUM_W'(2);
  assign avg_o  = sum[SUM_W-1:2];

endmodule

>>> rtl/core/ibd_line_mem.sv
// Line store of pair sums from the last even row, one entry per column pair.
// Depends on ibd_pkg.
module ibd_line_mem
  import ibd_pkg::*;
(
  input  logic              clk_i,
  input  line_req_t         req_i,
  output logic [LINE_W-1:0] rdata_o
);

  logic [LINE_W-1:0] mem_q [LINE_DEPTH];
  logic [LINE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/ibd_out_buf.sv
// Output register plus skid stage that holds the merged lane results.
// Depends on ibd_pkg.
module ibd_out_buf
  import ibd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  pix_out_t data_i,
  output logic     full_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pix_out_t out_pix_o
);

  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  pix_out_t out_q, out_d;
  pix_out_t skid_q, skid_d;
  logic     take;

  assign take = out_valid_q & ~out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || take) begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_q;

endmodule

>>> rtl/core/ibd_checker.sv
// Port-level checker for the 2x2 box downscaler, bound to the top level.
// Depends on ibd_pkg and image_box_downscale_2x2_top_macros.svh.
`include "image_box_downscale_2x2_top_macros.svh"

module ibd_checker
  import ibd_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input pix_out_t          out_pix_o,
  input logic              pready
);

  `IBD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_pix_o), "stalled result changed")
  `IBD_ASSERT(a_stall_has_result, !in_stall_o || out_valid_o, "input stalled with no result held")
  `IBD_ASSERT(a_stall_rise, !$rose(in_stall_o) || $past(out_stall_i), "input stall rose without output stall")
  `IBD_ASSERT(a_pready_high, pready, "pready dropped")

endmodule

bind image_box_downscale_2x2_top ibd_checker u_ibd_checker (.*);

>>> dv/tb_image_box_downscale_2x2_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the 2x2 box downscaler: streams RGB frames of many sizes.
// Predicts every block average in-bench. Depends on ibd_pkg and image_box_downscale_2x2_top.
module tb_image_box_downscale_2x2_top;
  import ibd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned RAND_PIXELS = 1850;
  localparam logic [APB_AW-1:0] ADDR_WIDTH  = {REG_WIDTH, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_HEIGHT = {REG_HEIGHT, 2'b00};

  typedef enum int {PACE_SLOW_RX, PACE_SLOW_TX, PACE_FULL} pace_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  pix_in_t           in_pix_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  pix_out_t          out_pix_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  image_box_downscale_2x2_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_pix_i   (in_pix_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_pix_o  (out_pix_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  pix_in_t           pix_q[$];
  pix_out_t          avg_expq[$];
  bit                in_xfer = 1'b0;
  int unsigned       snd_idle_pct = 0;
  int unsigned       rcv_idle_pct = 0;
  int unsigned       hold_left = 0;
  int unsigned       cycle_cnt = 0;
  int unsigned       err_cnt = 0;
  int unsigned       n_accepted = 0;
  int unsigned       n_checked = 0;
  int unsigned       n_frame_ends = 0;
  int unsigned       n_settings = 0;

  // predictor state
  logic [SIZE_W-1:0] m_width = WIDTH_RST;
  logic [SIZE_W-1:0] m_height = HEIGHT_RST;
  int unsigned       m_col = 0;
  int unsigned       m_row = 0;
  pix_in_t           m_held = '0;
  logic [LINE_W-1:0] m_line [LINE_DEPTH];

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned maxv);
    if (v == '0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [CHAN_W-1:0] box_avg(logic [PAIR_W-1:0] a, logic [PAIR_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b) + SUM_W'(2);
    return s[SUM_W-1:2];
  endfunction

  function automatic bit downscale_step(pix_in_t p, output pix_out_t r);
    int unsigned       w;
    int unsigned       h;
    int unsigned       slot;
    logic [PAIR_W-1:0] pr;
    logic [PAIR_W-1:0] pg;
    logic [PAIR_W-1:0] pb;
    logic [LINE_W-1:0] above;
    bit                got;
    w = eff_size(m_width, MAX_WIDTH);
    h = eff_size(m_height, MAX_HEIGHT);
    got = 1'b0;
    r = '0;
    if (m_col[0] == 1'b0) begin
      m_held = p;
    end else begin
      slot = (m_col >> 1) % LINE_DEPTH;
      pr = PAIR_W'(m_held.red_in) + PAIR_W'(p.red_in);
      pg = PAIR_W'(m_held.green_in) + PAIR_W'(p.green_in);
      pb = PAIR_W'(m_held.blue_in) + PAIR_W'(p.blue_in);
      if (m_row[0] == 1'b0) begin
        m_line[slot] = {pb, pg, pr};
      end else begin
        above = m_line[slot];
        r.red_out    = box_avg(above[PAIR_W-1:0], pr);
        r.green_out  = box_avg(above[2*PAIR_W-1:PAIR_W], pg);
        r.blue_out   = box_avg(above[3*PAIR_W-1:2*PAIR_W], pb);
        r.frame_last = (m_col + 2 >= w) && (m_row + 2 >= h);
        got = 1'b1;
      end
    end
    if (m_col + 1 >= w) begin
      m_col = 0;
      m_row = (m_row + 1 >= h) ? 0 : m_row + 1;
    end else begin
      m_col = m_col + 1;
    end
    return got;
  endfunction

  task automatic note_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endtask

  // sender: hold a stalled transfer, else offer the next pixel unless idling
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_xfer)) begin
      if (pix_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_valid_i <= 1'b1;
        in_pix_i   <= pix_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    pix_out_t want;
    pix_out_t seen;
    if (!rst_ni) begin
      in_xfer = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        seen = out_pix_o;
        if (avg_expq.size() == 0) begin
          note_error($sformatf("unexpected result r=%0d g=%0d b=%0d last=%0b",
                               seen.red_out, seen.green_out, seen.blue_out, seen.frame_last));
        end else begin
          want = avg_expq.pop_front();
          n_checked++;
          if (want.frame_last) n_frame_ends++;
          if (seen.red_out !== want.red_out || seen.green_out !== want.green_out ||
              seen.blue_out !== want.blue_out || seen.frame_last !== want.frame_last) begin
            note_error($sformatf({"average mismatch exp r=%0d g=%0d b=%0d last=%0b",
                                  " got r=%0d g=%0d b=%0d last=%0b"},
                                 want.red_out, want.green_out, want.blue_out, want.frame_last,
                                 seen.red_out, seen.green_out, seen.blue_out, seen.frame_last));
          end
        end
      end
      in_xfer = in_valid_i && !in_stall_o;
      if (in_xfer) begin
        n_accepted++;
        if (downscale_step(in_pix_i, want)) avg_expq.push_back(want);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_image_box_downscale_2x2_top NOT OK");
      $finish;
    end
  end

  task automatic apb_access(bit wr, logic [APB_AW-1:0] a, logic [APB_DW-1:0] d,
                            output logic [APB_DW-1:0] q);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = a;
    pwdata = d;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    q = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_reg(logic [APB_AW-1:0] a, logic [SIZE_W-1:0] v);
    logic [APB_DW-1:0] rd;
    apb_access(1'b0, a, '0, rd);
    if (rd[SIZE_W-1:0] !== v) begin
      note_error($sformatf("register at 0x%0h reads %0d, exp %0d", a, rd[SIZE_W-1:0], v));
    end
  endtask

  task automatic set_size(logic [APB_AW-1:0] a, logic [SIZE_W-1:0] v);
    logic [APB_DW-1:0] rd;
    apb_access(1'b1, a, APB_DW'(v), rd);
    if (a == ADDR_WIDTH) m_width = v;
    else m_height = v;
    m_col = 0;
    m_row = 0;
    check_reg(a, v);
  endtask

  task automatic set_frame(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
    set_size(ADDR_WIDTH, w);
    set_size(ADDR_HEIGHT, h);
    n_settings++;
  endtask

  // advance until every pixel is taken and every average has come back
  task automatic wait_drained();
    do @(posedge clk_i); while (pix_q.size() != 0 || in_valid_i || avg_expq.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_pace(pace_e pace);
    case (pace)
      PACE_SLOW_RX: begin
        snd_idle_pct = 21;
        rcv_idle_pct = 75;
      end
      PACE_SLOW_TX: begin
        snd_idle_pct = 75;
        rcv_idle_pct = 21;
      end
      default: begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
    endcase
  endtask

  function automatic pix_in_t mk_pix(int unsigned r, int unsigned g, int unsigned b);
    pix_in_t p;
    p.red_in   = CHAN_W'(r);
    p.green_in = CHAN_W'(g);
    p.blue_in  = CHAN_W'(b);
    return p;
  endfunction

  function automatic logic [CHAN_W-1:0] rand_chan();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) return '0;
    if (pick < 16) return '1;
    return CHAN_W'($urandom_range(255));
  endfunction

  task automatic push_random(int unsigned n);
    pix_in_t p;
    repeat (n) begin
      p.red_in   = rand_chan();
      p.green_in = rand_chan();
      p.blue_in  = rand_chan();
      pix_q.push_back(p);
    end
  endtask

  function automatic logic [SIZE_W-1:0] rand_dim(int unsigned hi);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) return '0;
    if (pick < 10) return SIZE_W'(1);
    return SIZE_W'($urandom_range(2, hi));
  endfunction

  initial begin
    int unsigned       rand_sent;
    int unsigned       ew;
    int unsigned       eh;
    int unsigned       npix;
    bit                hold_done;
    logic [SIZE_W-1:0] wv;
    logic [SIZE_W-1:0] hv;
    rand_sent = 0;
    hold_done = 1'b0;
    set_pace(PACE_SLOW_RX);
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    check_reg(ADDR_WIDTH, WIDTH_RST);
    check_reg(ADDR_HEIGHT, HEIGHT_RST);

    // full-scale and rounding corners in a 4x2 frame
    set_frame(SIZE_W'(4), SIZE_W'(2));
    pix_q.push_back(mk_pix(255, 255, 255));
    pix_q.push_back(mk_pix(255, 255, 255));
    pix_q.push_back(mk_pix(0, 0, 1));
    pix_q.push_back(mk_pix(0, 1, 1));
    pix_q.push_back(mk_pix(255, 255, 255));
    pix_q.push_back(mk_pix(254, 255, 255));
    pix_q.push_back(mk_pix(1, 0, 1));
    pix_q.push_back(mk_pix(1, 0, 0));
    wait_drained();
    // odd last column and row dropped
    set_frame(SIZE_W'(3), SIZE_W'(3));
    push_random(9);
    wait_drained();
    // single column, zero width, zero height: no block completes
    set_frame(SIZE_W'(1), SIZE_W'(2));
    push_random(2);
    wait_drained();
    set_frame(SIZE_W'(0), SIZE_W'(3));
    push_random(2);
    wait_drained();
    set_frame(SIZE_W'(2), SIZE_W'(0));
    push_random(2);
    wait_drained();

    while (rand_sent < RAND_PIXELS) begin
      if (rand_sent < RAND_PIXELS / 3) set_pace(PACE_SLOW_RX);
      else if (rand_sent < 2 * RAND_PIXELS / 3) set_pace(PACE_SLOW_TX);
      else set_pace(PACE_FULL);
      wv = rand_dim(20);
      hv = rand_dim(10);
      if ($urandom_range(3) == 0) begin
        // rewrite one register only: counters restart on the old size of the other
        if ($urandom_range(1) == 0) set_size(ADDR_WIDTH, wv);
        else set_size(ADDR_HEIGHT, hv);
        n_settings++;
      end else begin
        set_frame(wv, hv);
      end
      ew = eff_size(m_width, MAX_WIDTH);
      eh = eff_size(m_height, MAX_HEIGHT);
      if (ew < 2 || eh < 2 || ew * eh > 400) begin
        npix = $urandom_range(1, 12);
      end else begin
        npix = $urandom_range(1, 3) * ew * eh;
        if ($urandom_range(3) == 0) npix += $urandom_range(1, ew * eh - 1);
      end
      if (rand_sent + npix > RAND_PIXELS) npix = RAND_PIXELS - rand_sent;
      push_random(npix);
      rand_sent += npix;
      if (!hold_done && npix >= 60) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      wait_drained();
    end

    // size limits: oversize values act as the maximum
    set_pace(PACE_FULL);
    set_frame(SIZE_W'(4095), SIZE_W'(4));
    push_random(16);
    wait_drained();
    set_frame(SIZE_W'(4), SIZE_W'(4095));
    push_random(16);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (avg_expq.size() != 0) note_error("averages still outstanding at end of run");
    $display("Streamed %0d pixels over %0d size settings (zero, one, odd, oversize).",
             n_accepted, n_settings);
    $display("Checked %0d block averages, %0d frame ends, %0d errors.",
             n_checked, n_frame_ends, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_image_box_downscale_2x2_top OK");
    end else begin
      $display("tb_image_box_downscale_2x2_top NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/ibd_pkg.sv
rtl/core/ibd_lane.sv
rtl/core/ibd_line_mem.sv
rtl/core/ibd_out_buf.sv
rtl/core/image_box_downscale_2x2_top.sv
rtl/core/ibd_checker.sv
dv/tb_image_box_downscale_2x2_top.sv
